// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define AST_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define AST_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define AST_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/irpwd_pkg.sv -----
// Types, constants and window helpers for the IR pulse width decoder.
package irpwd_pkg;

    localparam int unsigned TICK_W  = 24;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned COUNT_W = 6;

    localparam logic [TICK_W-1:0] START_RESET = 24'd144000;
    localparam logic [TICK_W-1:0] ZERO_RESET  = 24'd19200;
    localparam logic [TICK_W-1:0] ONE_RESET   = 24'd48000;
    localparam logic [TICK_W-1:0] TOL_RESET   = 24'd6400;

    localparam logic [COUNT_W-1:0] WORD_BITS = 6'd32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

    typedef enum logic [1:0] {
        CFG_START = 2'd0,
        CFG_ZERO  = 2'd1,
        CFG_ONE   = 2'd2,
        CFG_TOL   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              lo_neg;
        logic [TICK_W-1:0] lo;
        logic [TICK_W:0]   hi;
    } t_window;

    function automatic t_window win_calc(input logic [TICK_W-1:0] centre,
                                         input logic [TICK_W-1:0] tol);
        t_window       w;
        logic [TICK_W:0] diff;
        diff     = {1'b0, centre} - {1'b0, tol};
        w.lo_neg = diff[TICK_W];
        w.lo     = diff[TICK_W-1:0];
        w.hi     = {1'b0, centre} + {1'b0, tol};
        return w;
    endfunction

    function automatic logic win_hit(input logic [STAMP_W-1:0] pulse,
                                     input t_window w);
        logic lo_ok;
        logic hi_ok;
        lo_ok = w.lo_neg || (pulse > {{(STAMP_W-TICK_W){1'b0}}, w.lo});
        hi_ok = {{(STAMP_W-TICK_W-1){1'b0}}, w.hi} > pulse;
        return lo_ok && hi_ok;
    endfunction

endpackage

// ----- rtl/core/ir_pulse_width_decoder.sv -----
// An accepted edge word is registered in the input stage, its result word in the
// state stage. Throughput: one edge word per cycle while the result side does not
// stall; the only loop is the state update stage. Window bounds are registered from
// the configuration registers after a write. Synchronous active-low reset clears
// state and handshakes and loads register defaults; no clearing pass is needed.
`include "assert_macros.svh"

module ir_pulse_width_decoder
    import irpwd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_pin_level,
    input  logic [STAMP_W-1:0]  i_timestamp,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STAMP_W-1:0]  o_command_word,
    output logic                o_word_ready,
    output logic [COUNT_W-1:0]  o_bits_received,
    output logic                o_completed_now,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [TICK_W-1:0]   i_cfg_data
);

    logic [TICK_W-1:0]  r_start_ticks;
    logic [TICK_W-1:0]  r_zero_ticks;
    logic [TICK_W-1:0]  r_one_ticks;
    logic [TICK_W-1:0]  r_tol_ticks;
    t_window            r_win_start;
    t_window            r_win_zero;
    t_window            r_win_one;

    logic               r_in_valid;
    logic               r_level;
    logic [STAMP_W-1:0] r_stamp;

    logic               r_out_valid;
    logic [STAMP_W-1:0] r_last_time;
    logic [COUNT_W-1:0] r_bit_count;
    logic [STAMP_W-1:0] r_shift_word;
    logic               r_ready_flag;
    logic               r_done;

    logic               n_level;
    logic [COUNT_W-1:0] n_bit_count;
    logic [STAMP_W-1:0] n_shift_word;
    logic               n_ready_flag;
    logic               n_done;

    logic               fire;
    logic [STAMP_W:0]   diff;
    logic [STAMP_W-1:0] pulse;
    logic               hit_start;
    logic               hit_zero;
    logic               hit_one;
    logic [COUNT_W-1:0] count_inc;

    // config port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_ticks <= START_RESET;
            r_zero_ticks  <= ZERO_RESET;
            r_one_ticks   <= ONE_RESET;
            r_tol_ticks   <= TOL_RESET;
            r_win_start   <= win_calc(START_RESET, TOL_RESET);
            r_win_zero    <= win_calc(ZERO_RESET, TOL_RESET);
            r_win_one     <= win_calc(ONE_RESET, TOL_RESET);
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_START: r_start_ticks <= i_cfg_data;
                    CFG_ZERO:  r_zero_ticks  <= i_cfg_data;
                    CFG_ONE:   r_one_ticks   <= i_cfg_data;
                    CFG_TOL:   r_tol_ticks   <= i_cfg_data;
                    default:   r_tol_ticks   <= r_tol_ticks;
                endcase
            end
            r_win_start <= win_calc(r_start_ticks, r_tol_ticks);
            r_win_zero  <= win_calc(r_zero_ticks, r_tol_ticks);
            r_win_one   <= win_calc(r_one_ticks, r_tol_ticks);
        end
    end

    // handshake
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    // pulse measurement and classification
    assign diff      = {1'b0, r_stamp} - {1'b0, r_last_time};
    assign pulse     = (!diff[STAMP_W] && (diff[STAMP_W-1:0] != '0)) ?
                       diff[STAMP_W-1:0] : '1;
    assign hit_start = win_hit(pulse, r_win_start);
    assign hit_zero  = win_hit(pulse, r_win_zero);
    assign hit_one   = win_hit(pulse, r_win_one);
    assign count_inc = (r_bit_count == COUNT_MAX) ? r_bit_count : r_bit_count + 1'b1;
    assign n_level   = r_level;

    always_comb begin
        n_bit_count  = r_bit_count;
        n_shift_word = r_shift_word;
        n_ready_flag = r_ready_flag;
        n_done       = 1'b0;
        if (!n_level) begin
            if (hit_start) begin
                n_bit_count  = '0;
                n_shift_word = '0;
                n_ready_flag = 1'b0;
            end else if (hit_zero) begin
                n_bit_count  = count_inc;
                n_shift_word = {1'b0, r_shift_word[STAMP_W-1:1]};
            end else if (hit_one) begin
                n_bit_count  = count_inc;
                n_shift_word = {1'b1, r_shift_word[STAMP_W-1:1]};
            end
            if (n_bit_count == WORD_BITS) begin
                n_ready_flag = 1'b1;
                n_done       = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_level <= i_pin_level;
            r_stamp <= i_timestamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_last_time  <= '0;
            r_bit_count  <= '0;
            r_shift_word <= '0;
            r_ready_flag <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            if (fire) begin
                r_out_valid  <= 1'b1;
                r_last_time  <= r_stamp;
                r_bit_count  <= n_bit_count;
                r_shift_word <= n_shift_word;
                r_ready_flag <= n_ready_flag;
                r_done       <= n_done;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // state doubles as the result word; it only moves when the result slot frees
    assign o_out_valid     = r_out_valid;
    assign o_command_word  = r_shift_word;
    assign o_word_ready    = r_ready_flag;
    assign o_bits_received = r_bit_count;
    assign o_completed_now = r_done;

    `AST_ALWAYS(a_done_count, !r_done || (r_ready_flag && (r_bit_count == WORD_BITS)),
                "completion without a full word")
    `AST_ALWAYS(a_ready_past_full, (r_bit_count < WORD_BITS) || r_ready_flag,
                "count past a full word without ready")
    `AST_NEXT(a_rise_no_done, fire && r_level, !r_done,
              "completion on a rising edge")
    `AST_SAME(a_stall_blocks, r_in_valid && r_out_valid && !i_out_ready, !o_in_ready,
              "input taken while both stages are held")

endmodule

// ----- tb/ir_pulse_width_decoder_tb.sv -----
// Self-checking testbench for the IR pulse width decoder: directed edges, then random frames.
module ir_pulse_width_decoder_tb
    import irpwd_pkg::*;
();

    localparam int SETTLE = 8;
    localparam int LIMIT  = 400000;
    localparam int NO_CAP = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [STAMP_W-1:0] word;
        logic               rdy;
        logic [COUNT_W-1:0] cnt;
        logic               done;
    } t_decode;

    typedef struct packed {
        logic               lvl;
        logic [STAMP_W-1:0] stamp;
        logic               typed;
        t_decode            val;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               pin_level = 1'b0;
    logic [STAMP_W-1:0] timestamp = '0;
    logic               out_ready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [TICK_W-1:0]  cfg_data = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [STAMP_W-1:0] o_command_word;
    logic               o_word_ready;
    logic [COUNT_W-1:0] o_bits_received;
    logic               o_completed_now;
    logic               o_cfg_ready;

    // predictor state and window setup
    logic [STAMP_W-1:0] last_stamp = '0;
    logic [COUNT_W-1:0] bit_cnt = '0;
    logic [STAMP_W-1:0] word_sr = '0;
    logic               ready_q = 1'b0;
    logic [TICK_W-1:0]  win_ticks [4];

    t_decode            decoded_q [$];
    t_row               dir_rows [24];
    logic [STAMP_W-1:0] timer_now = '0;
    logic               in_burst = 1'b0;
    logic               out_burst = 1'b0;
    int                 out_hold = 0;
    int                 errors = 0;
    int                 edges_sent = 0;
    int                 words_checked = 0;
    int                 completions = 0;
    int                 saturations = 0;
    int                 settings = 1;
    int                 cycles = 0;

    ir_pulse_width_decoder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_pin_level     (pin_level),
        .i_timestamp     (timestamp),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_command_word  (o_command_word),
        .o_word_ready    (o_word_ready),
        .o_bits_received (o_bits_received),
        .o_completed_now (o_completed_now),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit in_window(input logic [STAMP_W-1:0] width,
                                     input logic [TICK_W-1:0] centre);
        longint w;
        longint c;
        longint t;
        w = width;
        c = centre;
        t = win_ticks[CFG_TOL];
        return (w > c - t) && (w < c + t);
    endfunction

    function automatic t_decode decode_edge(input logic lvl, input logic [STAMP_W-1:0] stamp);
        t_decode            r;
        logic [STAMP_W-1:0] width;
        r.done = 1'b0;
        if (lvl) begin
            last_stamp = stamp;
        end else begin
            width = (stamp > last_stamp) ? stamp - last_stamp : '1;
            last_stamp = stamp;
            if (in_window(width, win_ticks[CFG_START])) begin
                bit_cnt = '0;
                ready_q = 1'b0;
                word_sr = '0;
            end else if (in_window(width, win_ticks[CFG_ZERO]) ||
                         in_window(width, win_ticks[CFG_ONE])) begin
                word_sr = {!in_window(width, win_ticks[CFG_ZERO]), word_sr[STAMP_W-1:1]};
                if (bit_cnt != COUNT_MAX)
                    bit_cnt = bit_cnt + 1'b1;
            end
            if (bit_cnt == WORD_BITS) begin
                ready_q = 1'b1;
                r.done = 1'b1;
            end
        end
        r.word = word_sr;
        r.rdy  = ready_q;
        r.cnt  = bit_cnt;
        return r;
    endfunction

    function automatic t_row mk_row(input logic lvl, input logic [STAMP_W-1:0] stamp,
                                    input logic typed, input logic [STAMP_W-1:0] word,
                                    input logic rdy, input logic [COUNT_W-1:0] cnt,
                                    input logic done);
        t_row r;
        r.lvl   = lvl;
        r.stamp = stamp;
        r.typed = typed;
        r.val   = {word, rdy, cnt, done};
        return r;
    endfunction

    // pulse length aimed at one window: mostly inside, sometimes on or near a bound
    function automatic logic [STAMP_W-1:0] draw_width(input t_cfg_idx which);
        longint c;
        longint t;
        longint w;
        int     pick;
        c = win_ticks[which];
        t = win_ticks[CFG_TOL];
        pick = $urandom_range(0, 9);
        if (pick < 7)
            w = (t == 0) ? c : c - t + 1 + longint'($urandom_range(0, 2 * t - 2));
        else
            w = c + ((pick == 7) ? -t : t) + longint'($urandom_range(0, 2)) - 1;
        if (w < 0)
            w = 0;
        return w[STAMP_W-1:0];
    endfunction

    task automatic check_field(input string name, input logic [STAMP_W-1:0] want,
                               input logic [STAMP_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    task automatic send_edge(input logic lvl, input logic [STAMP_W-1:0] stamp,
                             input logic typed, input t_decode typed_val);
        t_decode pred;
        int      gap;
        gap = in_burst ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        pin_level <= lvl;
        timestamp <= stamp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pred = decode_edge(lvl, stamp);
        decoded_q.push_back(typed ? typed_val : pred);
        edges_sent++;
    endtask

    task automatic send_pulse(input logic [STAMP_W-1:0] width);
        send_edge(1'b1, timer_now, 1'b0, '0);
        send_edge(1'b0, timer_now + width, 1'b0, '0);
        timer_now = timer_now + width + $urandom_range(1, 30000);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_edge(1'b0, $urandom, 1'b0, '0);
            1: send_edge(1'b1, $urandom, 1'b0, '0);
            2: send_pulse($urandom);
            default: send_pulse($urandom_range(0, 1 << 25));
        endcase
    endtask

    // frame is cut short once the edge count reaches cap
    task automatic send_frame(input int nbits, input int cap);
        in_burst = ($urandom_range(0, 3) == 0);
        out_burst <= ($urandom_range(0, 3) == 0);
        timer_now = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 1 << 20)
                                                 : $urandom;
        send_pulse(draw_width(CFG_START));
        for (int k = 0; (k < nbits) && (edges_sent < cap); k++) begin
            if ($urandom_range(0, 7) == 0)
                send_noise();
            send_pulse(draw_width($urandom_range(0, 1) ? CFG_ONE : CFG_ZERO));
        end
    endtask

    function automatic int frame_bits();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 72;
        if (r == 1)
            return $urandom_range(1, 20);
        return $urandom_range(30, 36);
    endfunction

    task automatic run_frames(input int budget, input bit saturate_first);
        int base;
        base = edges_sent;
        if (saturate_first)
            send_frame(72, NO_CAP);
        while (edges_sent - base < budget)
            send_frame(frame_bits(), base + budget);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic load_windows(input logic [TICK_W-1:0] s, input logic [TICK_W-1:0] z,
                                input logic [TICK_W-1:0] o, input logic [TICK_W-1:0] t);
        logic [TICK_W-1:0] vals [4];
        vals = '{s, z, o, t};
        wait_idle();
        for (int k = 0; k < 4; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= t_cfg_idx'(k);
            cfg_data  <= vals[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            win_ticks[k] = vals[k];
        end
        cfg_valid <= 1'b0;
        repeat (SETTLE) @(posedge i_clk);
        settings++;
    endtask

    // result side: after each word taken, may drop ready unless in an output burst
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (out_hold != 0) begin
            out_hold = out_hold - 1;
            if (out_hold == 0)
                out_ready <= 1'b1;
        end else if (o_out_valid && out_ready) begin
            out_hold = out_burst ? 0 : $urandom_range(0, 4);
            if (out_hold != 0)
                out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_decode want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (decoded_q.size() == 0) begin
                errors++;
                $display("%0t: result word with nothing expected: word 0x%0h count %0d",
                         $time, o_command_word, o_bits_received);
            end else begin
                want = decoded_q.pop_front();
                check_field("command_word", want.word, o_command_word);
                check_field("word_ready", want.rdy, o_word_ready);
                check_field("bits_received", want.cnt, o_bits_received);
                check_field("completed_now", want.done, o_completed_now);
                words_checked++;
                completions += o_completed_now;
                saturations += (o_bits_received == COUNT_MAX);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, decoded_q.size());
            $display("[ir_pulse_width_decoder] ERROR");
            $finish;
        end
    end

    initial begin
        win_ticks = '{START_RESET, ZERO_RESET, ONE_RESET, TOL_RESET};
        dir_rows = '{
            mk_row(1'b0, 32'd0,          1'b1, 32'h0,         1'b0, 6'd0, 1'b0),
            mk_row(1'b1, 32'hFFFF_FFFF,  1'b1, 32'h0,         1'b0, 6'd0, 1'b0),
            mk_row(1'b0, 32'd0,          1'b1, 32'h0,         1'b0, 6'd0, 1'b0),
            mk_row(1'b0, 32'd19200,      1'b1, 32'h0,         1'b0, 6'd1, 1'b0),
            mk_row(1'b1, 32'd100000,     1'b0, 32'h0,         1'b0, 6'd0, 1'b0),
            mk_row(1'b0, 32'd148000,     1'b1, 32'h8000_0000, 1'b0, 6'd2, 1'b0),
            mk_row(1'b1, 32'd200000,     1'b0, 32'h0,         1'b0, 6'd0, 1'b0),
            mk_row(1'b0, 32'd254400,     1'b0, 32'h0,         1'b0, 6'd0, 1'b0),
            mk_row(1'b1, 32'd300000,     1'b0, 32'h0,         1'b0, 6'd0, 1'b0),
            mk_row(1'b0, 32'd341601,     1'b0, 32'h0,         1'b0, 6'd0, 1'b0),
            mk_row(1'b1, 32'd400000,     1'b0, 32'h0,         1'b0, 6'd0, 1'b0),
            mk_row(1'b0, 32'd412800,     1'b0, 32'h0,         1'b0, 6'd0, 1'b0),
            mk_row(1'b1, 32'd500000,     1'b0, 32'h0,         1'b0, 6'd0, 1'b0),
            mk_row(1'b0, 32'd525599,     1'b0, 32'h0,         1'b0, 6'd0, 1'b0),
            mk_row(1'b1, 32'd600000,     1'b0, 32'h0,         1'b0, 6'd0, 1'b0),
            mk_row(1'b0, 32'd600000,     1'b0, 32'h0,         1'b0, 6'd0, 1'b0),
            mk_row(1'b1, 32'd700000,     1'b0, 32'h0,         1'b0, 6'd0, 1'b0),
            mk_row(1'b0, 32'd844000,     1'b1, 32'h0,         1'b0, 6'd0, 1'b0),
            mk_row(1'b1, 32'd900000,     1'b0, 32'h0,         1'b0, 6'd0, 1'b0),
            mk_row(1'b0, 32'd1037601,    1'b0, 32'h0,         1'b0, 6'd0, 1'b0),
            mk_row(1'b1, 32'hFFFF_0000,  1'b0, 32'h0,         1'b0, 6'd0, 1'b0),
            mk_row(1'b0, 32'h0000_1000,  1'b0, 32'h0,         1'b0, 6'd0, 1'b0),
            mk_row(1'b1, 32'h7FFF_0000,  1'b0, 32'h0,         1'b0, 6'd0, 1'b0),
            mk_row(1'b0, 32'h7FFF_BB80,  1'b0, 32'h0,         1'b0, 6'd0, 1'b0)
        };
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_edge(dir_rows[k].lvl, dir_rows[k].stamp, dir_rows[k].typed, dir_rows[k].val);

        run_frames(90, 1'b1);
        load_windows(24'd300, 24'd40, 24'd100, 24'd10);
        run_frames(80, 1'b0);
        // tiny zero/one windows, the zero one with no lower limit; start at the top of the range
        load_windows(24'hFF_FFFF, 24'd1, 24'd3, 24'd2);
        run_frames(50, 1'b0);
        // zero tolerance: no pulse can match
        load_windows(24'd1, 24'd500, 24'd1000, 24'd0);
        run_frames(40, 1'b0);
        // tolerance at maximum: start window has no lower limit and takes every pulse below its top, ahead of zero/one
        load_windows(24'd5000, 24'd20000, 24'd60000, 24'hFF_FFFF);
        run_frames(40, 1'b0);
        load_windows(24'(100000 + $urandom_range(0, 50000)), 24'($urandom_range(1, 4000)),
                     24'($urandom_range(8000, 30000)), 24'($urandom_range(0, 5000)));
        run_frames(80, 1'b0);
        load_windows(START_RESET, ZERO_RESET, ONE_RESET, TOL_RESET);
        run_frames(50, 1'b0);

        wait_idle();
        $display("Summary: %0d edge words over %0d window settings, %0d results checked",
                 edges_sent, settings, words_checked);
        $display("Summary: %0d word completions, %0d results with a saturated bit count",
                 completions, saturations);
        if (errors == 0) begin
            $display("[ir_pulse_width_decoder] OK");
        end else begin
            $display("[ir_pulse_width_decoder] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/irpwd_pkg.sv
rtl/core/ir_pulse_width_decoder.sv
tb/ir_pulse_width_decoder_tb.sv
